/* sv/assert_macros.svh */
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define FCFL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcfl assertion failed");

// next-cycle implication, held off during reset
`define FCFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcfl assertion failed");

`endif

/* sv/fcfl_pkg.sv */
// shared types, widths and codes of the chain free-list engine
package fcfl_pkg;

  localparam int ENTRIES_DEFAULT = 2048;

  localparam int MODE_W = 3;
  localparam int BLK_W  = 16;
  localparam int CNT_W  = 12;
  localparam int ST_W   = 2;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 24;

  localparam logic [MODE_W-1:0] MODE_FORMAT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WALK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EXTEND = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CUT    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_ENDED = 2'd2;
  localparam logic [ST_W-1:0] ST_LIMIT = 2'd3;

  // answer of the range unit: block lies in the table, and its offset from base
  typedef struct packed {
    logic             hit;
    logic [BLK_W-1:0] off;
  } range_res_t;

endpackage

/* sv/fcfl_range_unit.sv */
// shared block range check and offset subtractor
module fcfl_range_unit #(
  parameter int ENTRIES = fcfl_pkg::ENTRIES_DEFAULT
) (
  input  logic [fcfl_pkg::BLK_W-1:0] blk,
  input  logic [fcfl_pkg::BLK_W-1:0] base,
  output fcfl_pkg::range_res_t       res
);
  import fcfl_pkg::*;

  localparam logic [BLK_W:0] ENT_X = (BLK_W+1)'(ENTRIES);

  logic [BLK_W:0] diff;

  assign diff    = {1'b0, blk} - {1'b0, base};
  assign res.hit = (blk != '0) && !diff[BLK_W] && (diff < ENT_X);
  assign res.off = diff[BLK_W-1:0];

endmodule

/* sv/fcfl_link_ram.sv */
// link table memory, one write port and one registered read port
module fcfl_link_ram #(
  parameter int ENTRIES = fcfl_pkg::ENTRIES_DEFAULT,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [fcfl_pkg::BLK_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [fcfl_pkg::BLK_W-1:0] rdata
);
  import fcfl_pkg::*;

  logic [BLK_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/fat_chain_free_list_engine.sv */
// top level of the chain free-list engine over a fat style link table
// channels: slave stream takes one command transaction, tdata = mode [2:0],
//   first_block [18:3], link_count [30:19]; master stream returns one result
//   transaction per command, tdata = block [15:0], status [17:16]
// cfg_we/cfg_wdata write base_block, the block held by table entry zero;
//   only write it while no command is in flight
// one command at a time; s_axis_tready is high only while the sequencer idles
// each command runs as a sequence of steps, each step addressing one table entry:
//   format sweeps every entry, allocate pops the head, walk follows n links,
//   extend follows t tail links and appends a blocks,
//   cut keeps k links and frees f blocks, free chain frees f blocks
// every range check goes through one shared subtract-and-compare unit
// the result sits in an output register; a new command is taken while it
//   waits, and a command that finishes holds in its last step until the
//   register is free, so a stalled receiver stalls the engine without loss
// reset clears the free-list head (empty list), sets base_block to 6 and
//   empties the output; the link table keeps no reset value, so format
//   before any other command that reads it
module fat_chain_free_list_engine #(
  parameter int ENTRIES = fcfl_pkg::ENTRIES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [fcfl_pkg::IN_W-1:0]  s_axis_tdata,   // mode, first_block, link_count
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [fcfl_pkg::OUT_W-1:0] m_axis_tdata,   // block, status
  input  logic                       cfg_we,
  input  logic [fcfl_pkg::BLK_W-1:0] cfg_wdata
);
  import fcfl_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int SW = AW + 1;
  localparam logic [SW-1:0]  STEP_LIM = SW'(ENTRIES);
  localparam logic [SW-1:0]  FMT_LAST = SW'(ENTRIES - 1);
  localparam logic [BLK_W:0] CNT_LIM  = (BLK_W+1)'(ENTRIES);

  // sequencer states
  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_FMT       = 5'd1;
  localparam logic [4:0] S_AL_CHK    = 5'd2;
  localparam logic [4:0] S_AL_WB     = 5'd3;
  localparam logic [4:0] S_W_RD      = 5'd4;
  localparam logic [4:0] S_W_WAIT    = 5'd5;
  localparam logic [4:0] S_E_START   = 5'd6;
  localparam logic [4:0] S_E_RD      = 5'd7;
  localparam logic [4:0] S_E_CHK     = 5'd8;
  localparam logic [4:0] S_A_CHK     = 5'd9;
  localparam logic [4:0] S_A_WAIT    = 5'd10;
  localparam logic [4:0] S_A_LINK    = 5'd11;
  localparam logic [4:0] S_A_FIN     = 5'd12;
  localparam logic [4:0] S_C_START   = 5'd13;
  localparam logic [4:0] S_C_RD      = 5'd14;
  localparam logic [4:0] S_C_CHK     = 5'd15;
  localparam logic [4:0] S_C_REST_RD = 5'd16;
  localparam logic [4:0] S_C_REST    = 5'd17;
  localparam logic [4:0] S_F_CHK     = 5'd18;
  localparam logic [4:0] S_F_WB      = 5'd19;
  localparam logic [4:0] S_DONE      = 5'd20;

  logic [4:0]       state;
  logic [BLK_W-1:0] base_block;
  logic [BLK_W-1:0] head;        // free-list head
  logic [BLK_W-1:0] cur;         // block the sequencer stands on
  logic [BLK_W-1:0] nb;          // block just popped off the free list
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] i;           // links followed or kept, or blocks appended
  logic [SW-1:0]    steps;       // loop guard, also the format sweep index
  logic             rd_ok;       // walk read hit the table
  logic [BLK_W-1:0] res_blk;
  logic [ST_W-1:0]  res_st;
  logic             out_valid;
  logic [BLK_W-1:0] out_blk;
  logic [ST_W-1:0]  out_st;

  logic [MODE_W-1:0] in_mode;
  logic [BLK_W-1:0]  in_start;
  logic [CNT_W-1:0]  in_count;
  logic              in_too_long;

  logic [BLK_W-1:0] chk_blk;
  range_res_t       rng;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [BLK_W-1:0] ram_wdata;
  logic [BLK_W-1:0] rdata;

  assign in_mode     = s_axis_tdata[MODE_W-1:0];
  assign in_start    = s_axis_tdata[MODE_W+BLK_W-1:MODE_W];
  assign in_count    = s_axis_tdata[MODE_W+BLK_W+CNT_W-1:MODE_W+BLK_W];
  assign in_too_long = {{(BLK_W+1-CNT_W){1'b0}}, in_count} > CNT_LIM;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W-BLK_W-ST_W){1'b0}}, out_st, out_blk};

  // the one range unit, fed by whichever block this step checks
  always_comb begin
    chk_blk = cur;
    if (state == S_AL_CHK || state == S_AL_WB || state == S_A_CHK ||
        state == S_A_WAIT) begin
      chk_blk = head;
    end else if (state == S_E_CHK || state == S_C_CHK) begin
      chk_blk = rdata;
    end
  end

  fcfl_range_unit #(.ENTRIES(ENTRIES)) u_range (
    .blk  (chk_blk),
    .base (base_block),
    .res  (rng)
  );

  // table writes; any block outside the table is never written
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rng.off[AW-1:0];
    ram_wdata = '0;
    unique case (state)
      S_FMT: begin
        ram_we    = 1'b1;
        ram_waddr = steps[AW-1:0];
        if (steps != '0 && steps != FMT_LAST) begin
          ram_wdata = base_block + BLK_W'(steps) + BLK_W'(1);
        end
      end
      S_AL_WB, S_A_WAIT, S_A_FIN, S_C_REST: begin
        ram_we = rng.hit;
      end
      S_A_LINK: begin
        ram_we    = rng.hit;
        ram_wdata = nb;
      end
      S_F_WB: begin
        ram_we    = rng.hit;
        ram_wdata = head;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fcfl_link_ram #(.ENTRIES(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rng.off[AW-1:0]),
    .rdata (rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_block <= 16'd6;
    end else if (cfg_we) begin
      base_block <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      // the done step reloads the output itself when it is taken
      if (out_valid && m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            res_blk <= '0;
            res_st  <= ((in_mode == MODE_WALK || in_mode == MODE_CUT) && in_too_long) ?
                       ST_LIMIT : ST_OK;
            cur     <= in_start;
            count   <= in_count;
            i       <= '0;
            steps   <= '0;
            unique case (in_mode)
              MODE_FORMAT: state <= S_FMT;
              MODE_ALLOC:  state <= S_AL_CHK;
              MODE_WALK: begin
                if (in_too_long) begin
                  state <= S_DONE;
                end else begin
                  state <= S_W_RD;
                end
              end
              MODE_EXTEND: state <= S_E_START;
              MODE_CUT: begin
                if (in_too_long) begin
                  state <= S_DONE;
                end else begin
                  state <= S_C_START;
                end
              end
              MODE_FREE:   state <= S_F_CHK;
              default:     state <= S_DONE;
            endcase
          end
        end
        // format sweep, one entry a cycle
        S_FMT: begin
          if (steps == FMT_LAST) begin
            head  <= base_block + BLK_W'(1);
            state <= S_DONE;
          end else begin
            steps <= steps + SW'(1);
          end
        end
        // allocate: pop the head, clear its link
        S_AL_CHK: begin
          if (!rng.hit) begin
            res_st <= ST_EMPTY;
            state  <= S_DONE;
          end else begin
            state <= S_AL_WB;
          end
        end
        S_AL_WB: begin
          res_blk <= head;
          head    <= rdata;
          state   <= S_DONE;
        end
        // walk: for each link, a read step then a wait step
        S_W_RD: begin
          if (i == count || cur == '0) begin
            res_blk <= cur;
            res_st  <= (cur == '0) ? ST_ENDED : ST_OK;
            state   <= S_DONE;
          end else begin
            rd_ok <= rng.hit;
            state <= S_W_WAIT;
          end
        end
        S_W_WAIT: begin
          cur   <= rd_ok ? rdata : '0;
          i     <= i + CNT_W'(1);
          state <= S_W_RD;
        end
        // extend: tail search, then append
        S_E_START: begin
          if (!rng.hit) begin
            res_st <= ST_ENDED;
            state  <= S_DONE;
          end else begin
            state <= S_E_RD;
          end
        end
        S_E_RD: state <= S_E_CHK;
        S_E_CHK: begin
          if (rdata == '0) begin
            state <= S_A_CHK;
          end else if (!rng.hit) begin
            res_st <= ST_ENDED;
            state  <= S_DONE;
          end else if (steps == STEP_LIM) begin
            res_st <= ST_LIMIT;
            state  <= S_DONE;
          end else begin
            cur   <= rdata;
            steps <= steps + SW'(1);
            state <= S_E_RD;
          end
        end
        S_A_CHK: begin
          if (i == count) begin
            state <= S_A_FIN;
          end else if (!rng.hit) begin
            res_st <= ST_EMPTY;
            state  <= S_A_FIN;
          end else begin
            state <= S_A_WAIT;
          end
        end
        S_A_WAIT: begin
          nb    <= head;
          head  <= rdata;
          state <= S_A_LINK;
        end
        S_A_LINK: begin
          cur   <= nb;
          i     <= i + CNT_W'(1);
          state <= S_A_CHK;
        end
        S_A_FIN: begin
          res_blk <= cur;
          state   <= S_DONE;
        end
        // cut: keep count links, terminate, free the rest
        S_C_START: begin
          if (!rng.hit) begin
            res_st <= ST_ENDED;
            state  <= S_DONE;
          end else begin
            state <= S_C_RD;
          end
        end
        S_C_RD: begin
          state <= (i == count) ? S_C_REST_RD : S_C_CHK;
        end
        S_C_CHK: begin
          if (!rng.hit) begin
            res_st <= ST_ENDED;
            state  <= S_DONE;
          end else begin
            cur   <= rdata;
            i     <= i + CNT_W'(1);
            state <= S_C_RD;
          end
        end
        S_C_REST_RD: state <= S_C_REST;
        S_C_REST: begin
          res_blk <= cur;
          cur     <= rdata;
          steps   <= '0;
          state   <= S_F_CHK;
        end
        // freeing pass, pushes one block per check and write-back step
        S_F_CHK: begin
          if (!rng.hit) begin
            state <= S_DONE;
          end else if (steps == STEP_LIM) begin
            res_st <= ST_LIMIT;
            state  <= S_DONE;
          end else begin
            state <= S_F_WB;
          end
        end
        S_F_WB: begin
          head  <= cur;
          cur   <= rdata;
          steps <= steps + SW'(1);
          state <= S_F_CHK;
        end
        // hand the result over once the output register is free
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_blk   <= res_blk;
            out_st    <= res_st;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/fcfl_checker.sv */
// port-level checker for the chain free-list engine, with its bind
`include "assert_macros.svh"

module fcfl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [fcfl_pkg::OUT_W-1:0] m_axis_tdata
);
  import fcfl_pkg::*;

  // a stalled result stays put
  `FCFL_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // a command keeps the engine busy for at least the next cycle
  `FCFL_ASSERT_NEXT(a_busy_after_cmd, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // padding bits above status stay clear
  `FCFL_ASSERT_IMP(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[OUT_W-1:BLK_W+ST_W] == '0)

  // a chain that ended early never reports a block
  `FCFL_ASSERT_IMP(a_ended_no_blk, clk, rst, m_axis_tvalid && (m_axis_tdata[BLK_W+ST_W-1:BLK_W] == ST_ENDED), m_axis_tdata[BLK_W-1:0] == '0)

endmodule

bind fat_chain_free_list_engine fcfl_checker u_fcfl_checker (.*);

/* dv/fcfl_chain_checker.sv */
// checker for the chain free-list engine: predicts every result and compares it on the way out
module fcfl_chain_checker #(
  parameter int ENTRIES = fcfl_pkg::ENTRIES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [fcfl_pkg::IN_W-1:0]  s_axis_tdata,   // mode, first_block, link_count
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [fcfl_pkg::OUT_W-1:0] m_axis_tdata,   // block, status
  input  logic                       cfg_we,
  input  logic [fcfl_pkg::BLK_W-1:0] cfg_wdata,
  output int                         fails,
  output int                         pending,
  output int                         checked
);
  import fcfl_pkg::*;

  localparam logic [BLK_W-1:0] BASE_AT_RESET = 16'd6;

  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic [BLK_W-1:0] blk;
  } chain_result_t;

  // own copy of the link table, free-list head and base
  logic [BLK_W-1:0] links [ENTRIES];
  logic [BLK_W-1:0] head;
  logic [BLK_W-1:0] base;
  chain_result_t    answers [$];
  int               nfail;
  int               ncheck;

  function automatic bit owned(input logic [BLK_W-1:0] b);
    return (b != '0) && (b >= base) && (int'(b - base) < ENTRIES);
  endfunction

  function automatic logic [BLK_W-1:0] next_of(input logic [BLK_W-1:0] b);
    return owned(b) ? links[int'(b - base)] : '0;
  endfunction

  function automatic void relink(input logic [BLK_W-1:0] b, input logic [BLK_W-1:0] v);
    if (owned(b)) links[int'(b - base)] = v;
  endfunction

  function automatic logic [BLK_W-1:0] take_free();
    logic [BLK_W-1:0] b;
    b = head;
    if (!owned(b)) return '0;
    head = next_of(b);
    relink(b, '0);
    return b;
  endfunction

  // pushes a chain onto the free list, true when the step limit stops it
  function automatic bit release_chain(input logic [BLK_W-1:0] first);
    logic [BLK_W-1:0] b, n;
    int steps;
    b = first;
    steps = 0;
    while (owned(b)) begin
      if (steps == ENTRIES) return 1'b1;
      n = next_of(b);
      relink(b, head);
      head = b;
      b = n;
      steps++;
    end
    return 1'b0;
  endfunction

  function automatic chain_result_t run_command(input logic [IN_W-1:0] word);
    logic [MODE_W-1:0] op;
    logic [BLK_W-1:0]  sb, t, n, nb, rest;
    logic [CNT_W-1:0]  lc;
    chain_result_t     r;
    int                steps;
    op = word[2:0];
    sb = word[18:3];
    lc = word[30:19];
    r.blk = '0;
    r.st = ST_OK;
    case (op)
      MODE_FORMAT: begin
        links[0] = '0;
        for (int i = 1; i < ENTRIES - 1; i++) links[i] = BLK_W'(int'(base) + i + 1);
        links[ENTRIES-1] = '0;
        head = base + 16'd1;
      end
      MODE_ALLOC: begin
        r.blk = take_free();
        if (r.blk == '0) r.st = ST_EMPTY;
      end
      MODE_WALK: begin
        if (lc > ENTRIES) begin
          r.st = ST_LIMIT;
        end else begin
          t = sb;
          for (int i = 0; i < lc && t != '0; i++) t = next_of(t);
          r.blk = t;
          if (t == '0) r.st = ST_ENDED;
        end
      end
      MODE_EXTEND: begin
        if (!owned(sb)) begin
          r.st = ST_ENDED;
        end else begin
          // tail search, bounded against looping chains
          t = sb;
          steps = 0;
          n = next_of(t);
          while (n != '0 && r.st == ST_OK) begin
            if (!owned(n)) r.st = ST_ENDED;
            else if (steps == ENTRIES) r.st = ST_LIMIT;
            else begin
              t = n;
              steps++;
              n = next_of(t);
            end
          end
          if (r.st == ST_OK) begin
            for (int i = 0; i < lc && r.st == ST_OK; i++) begin
              nb = take_free();
              if (nb == '0) r.st = ST_EMPTY;
              else begin
                relink(t, nb);
                t = nb;
              end
            end
            relink(t, '0);
            r.blk = t;
          end
        end
      end
      MODE_CUT: begin
        if (lc > ENTRIES) r.st = ST_LIMIT;
        else if (!owned(sb)) r.st = ST_ENDED;
        else begin
          t = sb;
          for (int i = 0; i < lc && r.st == ST_OK; i++) begin
            n = next_of(t);
            if (!owned(n)) r.st = ST_ENDED;
            else t = n;
          end
          if (r.st == ST_OK) begin
            rest = next_of(t);
            relink(t, '0);
            if (release_chain(rest)) r.st = ST_LIMIT;
            r.blk = t;
          end
        end
      end
      MODE_FREE: begin
        if (release_chain(sb)) r.st = ST_LIMIT;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    chain_result_t want, got;
    if (rst) begin
      head = '0;
      base = BASE_AT_RESET;
      answers.delete();
      nfail = 0;
      ncheck = 0;
    end else begin
      if (cfg_we) base = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) answers.push_back(run_command(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.blk = m_axis_tdata[15:0];
        got.st = m_axis_tdata[17:16];
        ncheck++;
        if (answers.size() == 0) begin
          nfail++;
          if (nfail <= 10)
            $display("result %0d arrived with nothing outstanding: block %0d status %0d",
                     ncheck, got.blk, got.st);
        end else begin
          want = answers.pop_front();
          if (got.blk !== want.blk || got.st !== want.st) begin
            nfail++;
            if (nfail <= 10)
              $display("result %0d: expected block %0d status %0d, got block %0d status %0d",
                       ncheck, want.blk, want.st, got.blk, got.st);
          end
        end
      end
    end
    fails <= nfail;
    checked <= ncheck;
    pending <= answers.size();
  end

endmodule

/* dv/fat_chain_free_list_engine_test.sv */
// testbench top for the chain free-list engine: stimulus, flow control and verdict
module fat_chain_free_list_engine_test;
  import fcfl_pkg::*;

  localparam int ENTRIES     = ENTRIES_DEFAULT;
  localparam int CYCLE_LIMIT = 50_000_000;  // far above the slowest plausible run
  localparam int HOLD_CYCLES = 400;         // long receiver hold-off in the last set
  localparam int PHASE_ITEMS = 235;
  localparam int ROOT_SLOTS  = 16;

  // modes the engine takes no action on, though each still gets a result
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam logic [BLK_W-1:0] BASE_AT_RESET = 16'd6;
  localparam logic [BLK_W-1:0] BASE_MIN      = 16'd1;
  localparam logic [BLK_W-1:0] BASE_MAX      = 16'd32768;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;    // mode [2:0], first_block [18:3], link_count [30:19]
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;         // block [15:0], status [17:16]
  logic             cfg_we = 1'b0;
  logic [BLK_W-1:0] cfg_wdata = '0;

  int fails, pending, checked;

  // stimulus knobs; the receiver knobs cross processes, so they change by nonblocking writes
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               hold_seq = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  int               sent = 0;                 // commands accepted, ignored modes not counted
  logic [BLK_W-1:0] cur_base = BASE_AT_RESET;
  int               cycles = 0;

  // chain heads learnt from returned transactions, used to aim commands at live chains
  logic [BLK_W-1:0] roots [ROOT_SLOTS];
  int               nroots = 0;
  logic [BLK_W-1:0] base_now = BASE_AT_RESET;
  logic [IN_W-1:0]  inflight [$];

  fat_chain_free_list_engine #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  fcfl_chain_checker #(.ENTRIES(ENTRIES)) chain_check (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .fails(fails),
    .pending(pending),
    .checked(checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run-length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // follows the transactions to learn live chain heads
  always @(posedge clk) begin
    logic [IN_W-1:0] cmd;
    if (cfg_we) begin
      base_now <= cfg_wdata;
      nroots <= 0;          // chains of the old base no longer mean much
    end
    if (s_axis_tvalid && s_axis_tready) inflight.push_back(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready && inflight.size() != 0) begin
      cmd = inflight.pop_front();
      case (cmd[2:0])
        MODE_FORMAT: begin
          // the block at entry zero is a one-block root chain
          roots[0] <= base_now;
          nroots <= 1;
        end
        MODE_ALLOC: begin
          if (m_axis_tdata[17:16] == ST_OK) begin
            if (nroots < ROOT_SLOTS) begin
              roots[nroots] <= m_axis_tdata[15:0];
              nroots <= nroots + 1;
            end else begin
              roots[$urandom_range(ROOT_SLOTS - 1, 1)] <= m_axis_tdata[15:0];
            end
          end
        end
        MODE_FREE: begin
          // a freed head is dead; zero makes a harmless start
          for (int j = 0; j < ROOT_SLOTS; j++)
            if (j < nroots && roots[j] == cmd[18:3]) roots[j] <= '0;
        end
        default: ;
      endcase
    end
  end

  // one command transaction, with a random gap in front of it
  task automatic issue(input logic [MODE_W-1:0] op, input logic [BLK_W-1:0] sb,
                       input logic [CNT_W-1:0] lc);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= $urandom;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, lc, sb, op};
    do @(posedge clk); while (!s_axis_tready);
    if (op != MODE_SPARE_LO && op != MODE_SPARE_HI) sent++;
  endtask

  // mostly commands aimed at live chains with short counts, some noise
  task automatic random_item();
    int r, p;
    logic [MODE_W-1:0] op;
    logic [BLK_W-1:0]  sb;
    logic [CNT_W-1:0]  lc;
    r = $urandom_range(99);
    if (r < 2) op = MODE_FORMAT;
    else if (r < 24) op = MODE_ALLOC;
    else if (r < 44) op = MODE_WALK;
    else if (r < 64) op = MODE_EXTEND;
    else if (r < 80) op = MODE_CUT;
    else if (r < 94) op = MODE_FREE;
    else op = ($urandom_range(1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;
    p = $urandom_range(99);
    if (p < 85 && nroots != 0) sb = roots[$urandom_range(nroots - 1)];
    else if (p < 95) sb = BLK_W'($urandom);
    else sb = BLK_W'(int'(cur_base) + $urandom_range(ENTRIES - 1));
    p = $urandom_range(99);
    if (p < 88) lc = CNT_W'($urandom_range(6));
    else if (p < 94) lc = CNT_W'($urandom_range(ENTRIES, 7));
    else lc = CNT_W'($urandom_range(4095, ENTRIES + 1));
    issue(op, sb, lc);
  endtask

  // drain: every expected result back, then a short pause so the engine is idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [BLK_W-1:0] b, input bit fmt, input int idle,
                           input int stall, input bit hold);
    int target;
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_base = b;
    idle_pct = idle;
    stall_pct <= stall;
    target = sent + PHASE_ITEMS;
    if (fmt) issue(MODE_FORMAT, '0, '0);
    if (hold) begin
      // start the hold-off only once the long format sweep is back
      settle();
      hold_seq <= hold_seq + 1;
    end
    while (sent < target) random_item();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before format: only commands that never read the table
    issue(MODE_ALLOC, '0, '0);                          // empty list after reset
    issue(MODE_WALK, 16'hFFFF, '0);                     // zero links returns the start
    issue(MODE_WALK, '0, 12'd5);                        // walk from the chain end
    issue(MODE_WALK, cur_base, 12'hFFF);                // walk longer than the table
    issue(MODE_EXTEND, '0, 12'd1);                      // bad start
    issue(MODE_CUT, 16'hFFFF, '0);                      // bad start
    issue(MODE_CUT, cur_base, 12'(ENTRIES + 1));        // cut beyond the limit
    issue(MODE_FREE, '0, '0);                           // nothing to free
    issue(MODE_SPARE_LO, 16'hFFFF, 12'hFFF);
    issue(MODE_SPARE_HI, '0, '0);

    // formatted table: the usual life of a chain
    issue(MODE_FORMAT, '0, '0);
    issue(MODE_ALLOC, '0, '0);                          // pops base+1
    issue(MODE_EXTEND, cur_base, 12'd3);
    issue(MODE_WALK, cur_base, 12'd3);                  // reaches the tail
    issue(MODE_WALK, cur_base, 12'd4);                  // runs off the end
    issue(MODE_CUT, cur_base, 12'd1);                   // keep one link, free the rest
    issue(MODE_CUT, cur_base, 12'd5);                   // cut past the end
    issue(MODE_EXTEND, cur_base + 16'd1, 12'(ENTRIES)); // drains the free list
    issue(MODE_ALLOC, '0, '0);                          // empty list
    issue(MODE_WALK, cur_base + 16'd1, 12'(ENTRIES));   // longest legal walk
    issue(MODE_FREE, cur_base + 16'd1, '0);             // gives the long chain back

    // freeing the head of a fresh list links it to itself, then looping chains hit the limit
    issue(MODE_FORMAT, '0, '0);
    issue(MODE_FREE, cur_base + 16'd1, '0);
    issue(MODE_EXTEND, cur_base + 16'd1, 12'd1);        // tail search never finds an end and stops at the limit
    issue(MODE_FREE, cur_base + 16'd1, '0);             // freeing pass never finds an end and stops at the limit

    // random sets over the base range and the flow-control mixes
    run_phase(BASE_MIN, 1'b1, 0, 0, 1'b0);
    run_phase(BASE_MAX, 1'b1, 58, 0, 1'b0);
    run_phase(BLK_W'($urandom_range(32767, 2)), 1'b1, 0, 58, 1'b0);
    run_phase(BLK_W'($urandom_range(32767, 2)), 1'b0, 16, 16, 1'b0);  // stale table
    run_phase(BASE_AT_RESET, 1'b1, 0, 0, 1'b1);         // receiver holds off after format
    settle();
    repeat (20) @(posedge clk);

    $display("%0d commands over six stimulus sets, %0d result transactions compared",
             sent, checked);
    $display("base_block from %0d to %0d, with sender gaps, receiver stalls and a %0d-cycle hold",
             BASE_MIN, BASE_MAX, HOLD_CYCLES);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", fails);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* fat_chain_free_list_engine.f */
+incdir+sv
sv/fcfl_pkg.sv
sv/fcfl_range_unit.sv
sv/fcfl_link_ram.sv
sv/fat_chain_free_list_engine.sv
sv/fcfl_checker.sv
dv/fcfl_chain_checker.sv
dv/fat_chain_free_list_engine_test.sv
